### sv/ptbbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptbbp_pkg;

   localparam int NUM_TYPES = 1024;
   localparam int ADDR_W    = $clog2(NUM_TYPES);

   localparam int TYPE_W    = 32;
   localparam int TIME_W    = 32;
   localparam int LEN_W     = 32;
   localparam int COUNT_W   = 32;
   localparam int USED_W    = 17;
   localparam int BUDGET_W  = 16;
   localparam int HEADER_W  = 8;
   localparam int FRAC_W    = 16;
   localparam int RATE_W    = 48;
   localparam int TOTAL_W   = LEN_W + 2;
   localparam int DIV_CNT_W = $clog2(RATE_W);

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_BUDGET  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = CSR_IDX_W'(1);

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(2048);
   localparam logic [HEADER_W-1:0] HEADER_RESET = HEADER_W'(12);

   localparam logic ACT_MESSAGE = 1'b0;
   localparam logic ACT_QUERY   = 1'b1;

   typedef struct packed {
      logic              action;
      logic [TYPE_W-1:0] msg_type;
      logic [TIME_W-1:0] msg_time;
      logic [LEN_W-1:0]  msg_len;
   } req_payload_type;

   typedef struct packed {
      logic               accepted;
      logic               has_messages;
      logic [COUNT_W-1:0] msg_count;
      logic [RATE_W-1:0]  avg_rate;
   } rsp_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  stamp;
      logic [USED_W-1:0]  used;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [RATE_W-1:0] dividend;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [RATE_W-1:0] quotient;
   } div_sts_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_DIV
   } state_type;

endpackage

`default_nettype wire

### sv/ptbbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ptbbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### sv/ptbbp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ptbbp_div
   import ptbbp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_sts_type      sts
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W:0]      rem_ff, rem_in;
   logic [RATE_W-1:0]    quo_ff, quo_in;
   logic [TIME_W-1:0]    den_ff, den_in;

   logic [TIME_W:0]      shifted;
   logic [TIME_W+1:0]    diff;
   logic                 ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff[TIME_W-1:0], quo_ff[RATE_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      ge      = ~diff[TIME_W+1];

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;

      if (req.start) begin
         run_in = 1'b1;
         cnt_in = DIV_CNT_W'(RATE_W - 1);
         rem_in = '0;
         quo_in = req.dividend;
         den_in = req.divisor;
      end else if (run_ff) begin
         rem_in = ge ? diff[TIME_W:0] : shifted;
         quo_in = {quo_ff[RATE_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

`default_nettype wire

### sv/per_type_byte_budget_policer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-type byte budget policer. After reset the block clears all NUM_TYPES (1024) entries of
// its entry memory, with busy high; configuration writes are taken during that time. An item
// is taken when start is high and busy is low. A message, or a query whose type is out of
// range or whose latest time is zero, keeps busy high only for ST_EXEC: a read of the type
// entry at the take and, for a message, its write-back, in a single memory with a registered
// read; no new item is taken until busy falls. A query with a nonzero latest time runs a
// one-bit-per-cycle divider over the 48-bit quotient and keeps busy high until it is done.
// Each result appears on rsp_data for exactly one cycle with rsp_valid high, in the cycle in
// which busy falls; it cannot be held off, so the receiver must take it then.
module per_type_byte_budget_policer_top
   import ptbbp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  start,
   output logic                       busy,
   input  wire req_payload_type       req_data,

   output logic                       rsp_valid,
   output rsp_payload_type            rsp_data,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;

   logic [BUDGET_W-1:0]  byte_budget_ff;
   logic [HEADER_W-1:0]  header_bytes_ff;
   logic [TIME_W-1:0]    latest_ff;

   logic                 action_ff;
   logic                 in_range_ff;
   logic [LEN_W-1:0]     len_ff;
   logic [ADDR_W-1:0]    addr_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 take;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   entry_type            ram_wr_data;
   entry_type            rd_entry;

   logic [USED_W-1:0]    used;
   logic [TOTAL_W-1:0]   total;
   logic                 fits;
   logic [COUNT_W-1:0]   count_next;

   div_req_type          div_req;
   div_sts_type          div_sts;

   assign take      = start & ~busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ptbbp_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(NUM_TYPES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (take),
      .rd_addr (req_data.msg_type[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   ptbbp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .sts   (div_sts)
   );

   // bytes of an entry written in an older slot count as zero
   always_comb begin
      used       = (rd_entry.stamp == latest_ff) ? rd_entry.used : '0;
      total      = TOTAL_W'(used) + TOTAL_W'(len_ff) + TOTAL_W'(header_bytes_ff);
      fits       = in_range_ff & (total <= TOTAL_W'(byte_budget_ff));
      count_next = (rd_entry.count == '1) ? rd_entry.count : rd_entry.count + 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = '0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      div_req          = '0;
      div_req.dividend = {rd_entry.count, FRAC_W'(0)};
      div_req.divisor  = latest_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            if (clr_addr_ff == ADDR_W'(NUM_TYPES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_data_in = '0;
            if (action_ff == ACT_MESSAGE) begin
               state_in             = ST_IDLE;
               rsp_valid_in         = 1'b1;
               rsp_data_in.accepted = fits;
               if (fits) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_data.used  = total[USED_W-1:0];
                  ram_wr_data.stamp = latest_ff;
                  ram_wr_data.count = count_next;
               end
            end else begin
               if (in_range_ff) begin
                  rsp_data_in.has_messages = (rd_entry.count != '0);
                  rsp_data_in.msg_count    = rd_entry.count;
               end
               if (in_range_ff && latest_ff != '0) begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.avg_rate = div_sts.quotient;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         byte_budget_ff  <= BUDGET_RESET;
         header_bytes_ff <= HEADER_RESET;
         latest_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         action_ff       <= ACT_MESSAGE;
         in_range_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BYTE_BUDGET:  byte_budget_ff  <= csr_wdata[BUDGET_W-1:0];
               CSR_HEADER_BYTES: header_bytes_ff <= csr_wdata[HEADER_W-1:0];
               default: ;
            endcase
         end
         if (take) begin
            action_ff   <= req_data.action;
            in_range_ff <= (req_data.msg_type < TYPE_W'(NUM_TYPES));
            // a newer timestamp opens a new slot, even for an out-of-range type
            if (req_data.action == ACT_MESSAGE && req_data.msg_time > latest_ff) begin
               latest_ff <= req_data.msg_time;
            end
         end
      end
      rsp_data_ff <= rsp_data_in;
      if (take) begin
         len_ff  <= req_data.msg_len;
         addr_ff <= req_data.msg_type[ADDR_W-1:0];
      end
   end

`ifndef SYNTHESIS
   a_take_to_exec: assert property (@(posedge clock) disable iff (reset)
      take |=> state_ff == ST_EXEC)
      else $error("accepted item did not enter execution");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_EXEC || $past(state_ff) == ST_DIV)
      else $error("result transfer without an item in work");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.msg_count == '0 && rsp_data.avg_rate == '0)
      else $error("message result carries query fields");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == ST_CLEAR || (state_ff == ST_EXEC && action_ff == ACT_MESSAGE))
      else $error("entry write outside clear pass or message update");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV)
      else $error("divider finished with no query waiting");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ptbbp_pkg::*;

   localparam int ITEMS_PER_SETTING = 200;
   localparam int SETTLE_CYCLES     = 80;
   localparam int STALL_LIMIT       = 5000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_payload_type       req_data  = '0;
   logic                  rsp_valid;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // policer image: limits and per-type table
   logic [BUDGET_W-1:0] budget_q    = BUDGET_RESET;
   logic [HEADER_W-1:0] header_q    = HEADER_RESET;
   logic [TIME_W-1:0]   newest_time = '0;
   logic [USED_W-1:0]   type_bytes [NUM_TYPES];
   logic [TIME_W-1:0]   type_slot  [NUM_TYPES];
   logic [COUNT_W-1:0]  type_count [NUM_TYPES];

   req_payload_type   pending_msgs[$];
   rsp_payload_type   expected_rsps[$];
   logic [TIME_W-1:0] gen_time     = '0;
   bit                no_gaps      = 1'b0;
   int                gap_left     = 0;
   int                items_queued = 0;
   int                rsps_matched = 0;
   int                mismatches   = 0;
   int                stall_cycles = 0;

   per_type_byte_budget_policer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic rsp_payload_type police(req_payload_type it);
      rsp_payload_type    res;
      logic [ADDR_W-1:0]  idx;
      logic [USED_W-1:0]  used;
      logic [TOTAL_W-1:0] total;
      logic               in_range;
      res      = '0;
      in_range = it.msg_type < NUM_TYPES;
      idx      = it.msg_type[ADDR_W-1:0];
      if (it.action == ACT_MESSAGE) begin
         if (it.msg_time > newest_time) newest_time = it.msg_time;
         if (in_range) begin
            // bytes from an older slot count as zero
            used  = (type_slot[idx] == newest_time) ? type_bytes[idx] : '0;
            total = TOTAL_W'(used) + TOTAL_W'(it.msg_len) + TOTAL_W'(header_q);
            if (total <= TOTAL_W'(budget_q)) begin
               type_bytes[idx] = total[USED_W-1:0];
               type_slot[idx]  = newest_time;
               if (type_count[idx] != '1) type_count[idx] = type_count[idx] + 1'b1;
               res.accepted = 1'b1;
            end
         end
      end else if (in_range) begin
         res.has_messages = type_count[idx] != '0;
         res.msg_count    = type_count[idx];
         if (newest_time != '0)
            res.avg_rate = RATE_W'({type_count[idx], FRAC_W'(0)} / RATE_W'(newest_time));
      end
      return res;
   endfunction

   function automatic void flag(string msg);
      if (mismatches < 10) $display("%0t: %s", $realtime, msg);
      mismatches++;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want)
         flag($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver: start stays high until the transfer, then the next item or a gap
   always @(posedge clock) begin
      logic holding;
      if (reset) begin
         start <= 1'b0;
      end else begin
         holding = start;
         if (start && !busy) begin
            expected_rsps.push_back(police(req_data));
            holding = 1'b0;
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_msgs.size() != 0) begin
               req_data <= pending_msgs.pop_front();
               start    <= 1'b1;
               gap_left = pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: results cannot be held off, so every strobe is a transfer
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            flag($sformatf("unexpected result %0h", rsp_data));
         end else begin
            want = expected_rsps.pop_front();
            check_field("accepted", 64'(want.accepted), 64'(rsp_data.accepted));
            check_field("has_messages", 64'(want.has_messages), 64'(rsp_data.has_messages));
            check_field("msg_count", 64'(want.msg_count), 64'(rsp_data.msg_count));
            check_field("avg_rate", 64'(want.avg_rate), 64'(rsp_data.avg_rate));
            rsps_matched++;
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic add_item(logic act, logic [TYPE_W-1:0] ty, logic [TIME_W-1:0] ts,
                           logic [LEN_W-1:0] len);
      if (act == ACT_MESSAGE && ts > gen_time) gen_time = ts;
      pending_msgs.push_back(req_payload_type'{act, ty, ts, len});
      items_queued++;
   endtask

   task automatic add_random_item();
      int                r;
      logic [TYPE_W-1:0] ty;
      logic [TIME_W-1:0] ts;
      logic [LEN_W-1:0]  len;
      r = $urandom_range(0, 99);
      if (r < 75) ty = $urandom_range(0, 7);
      else if (r < 88) ty = $urandom_range(0, NUM_TYPES - 1);
      else ty = $urandom_range(NUM_TYPES, 32'hFFFF_FFFF);
      // mostly the current slot or the next few, now and then an old or far time
      r = $urandom_range(0, 99);
      if (r < 50) ts = gen_time;
      else if (r < 80) ts = (gen_time > 32'hFFFF_FF00) ? gen_time : gen_time + $urandom_range(1, 3);
      else if (r < 96) ts = $urandom_range(0, gen_time);
      else ts = $urandom;
      r = $urandom_range(0, 99);
      if (r < 5) len = '0;
      else if (r < 70) len = $urandom_range(0, 600);
      else if (r < 90) len = $urandom_range(0, 70000);
      else len = $urandom;
      if ($urandom_range(0, 99) < 20) add_item(ACT_QUERY, ty, $urandom, $urandom);
      else add_item(ACT_MESSAGE, ty, ts, len);
   endtask

   task automatic wait_drained();
      while (rsps_matched != items_queued) @(posedge clock);
   endtask

   task automatic set_limits(logic [BUDGET_W-1:0] budget, logic [HEADER_W-1:0] header);
      csr_valid <= 1'b1;
      csr_index <= CSR_BYTE_BUDGET;
      csr_wdata <= {16'($urandom), budget};
      do @(posedge clock); while (!csr_ready);
      budget_q = budget;
      csr_index <= CSR_HEADER_BYTES;
      csr_wdata <= {24'($urandom), header};
      do @(posedge clock); while (!csr_ready);
      header_q = header;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [BUDGET_W-1:0] budgets [5];
      logic [HEADER_W-1:0] headers [5];
      foreach (type_bytes[i]) begin
         type_bytes[i] = '0;
         type_slot[i]  = '0;
         type_count[i] = '0;
      end
      budgets = '{16'd2048, 16'd65535, 16'd0, 16'd600, 16'($urandom)};
      headers = '{8'd12, 8'd255, 8'd0, 8'd0, 8'($urandom)};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset limits: zero time, out-of-range types, exact and overrun budgets, slots
      add_item(ACT_QUERY, 0, 32'h1234_5678, 32'hFFFF_FFFF);
      add_item(ACT_QUERY, NUM_TYPES, 0, 0);
      add_item(ACT_QUERY, 32'hFFFF_FFFF, 0, 0);
      add_item(ACT_MESSAGE, 0, 0, 0);
      add_item(ACT_MESSAGE, 0, 0, 32'hFFFF_FFFF);
      add_item(ACT_MESSAGE, 32'hFFFF_FFFF, 5, 0);
      add_item(ACT_MESSAGE, NUM_TYPES, 4, 0);
      add_item(ACT_QUERY, 0, 0, 0);
      add_item(ACT_MESSAGE, NUM_TYPES - 1, 5, 2036);
      add_item(ACT_MESSAGE, NUM_TYPES - 1, 5, 0);
      add_item(ACT_MESSAGE, NUM_TYPES - 1, 3, 0);
      add_item(ACT_MESSAGE, NUM_TYPES - 1, 6, 0);
      add_item(ACT_QUERY, NUM_TYPES - 1, 0, 0);
      add_item(ACT_MESSAGE, 0, 6, 2037);
      wait_drained();
      set_limits(16'd0, 8'd0);
      add_item(ACT_MESSAGE, 3, 6, 0);
      add_item(ACT_MESSAGE, 3, 6, 1);
      wait_drained();
      set_limits(16'hFFFF, 8'hFF);
      add_item(ACT_MESSAGE, 4, 7, 65280);
      add_item(ACT_MESSAGE, 4, 7, 0);
      add_item(ACT_QUERY, 4, 0, 0);
      wait_drained();

      foreach (budgets[p]) begin
         set_limits(budgets[p], headers[p]);
         no_gaps = (p == 2);
         repeat (ITEMS_PER_SETTING) add_random_item();
         wait_drained();
      end
      no_gaps = 1'b0;

      // newest possible time
      set_limits(16'hFFFF, 8'd0);
      add_item(ACT_MESSAGE, 5, 32'hFFFF_FFFF, 0);
      add_item(ACT_QUERY, 5, 0, 0);
      add_item(ACT_MESSAGE, 5, 0, 65535);
      add_item(ACT_QUERY, 4, 0, 0);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         flag($sformatf("%0d results never arrived", expected_rsps.size()));
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
